FILE: rtl/core/icu8_pkg.sv
package icu8_pkg;

    // Request kinds carried by one input item
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_ACK   = 2'd3
    } req_kind_t;

    // Initialisation sequence phases
    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ICW2 = 2'd1,
        PHASE_ICW3 = 2'd2,
        PHASE_ICW4 = 2'd3
    } init_phase_t;

    // OCW2 end-of-interrupt codes (bits 7..5)
    localparam logic [2:0] EOI_NON_SPECIFIC = 3'd1;
    localparam logic [2:0] EOI_SPECIFIC     = 3'd3;

    // Command byte bit positions
    localparam int unsigned CMD_ICW1_BIT   = 4;
    localparam int unsigned CMD_OCW3_BIT   = 3;
    localparam int unsigned ICW1_IC4_BIT   = 0;
    localparam int unsigned ICW1_SNGL_BIT  = 1;
    localparam int unsigned ICW1_LTIM_BIT  = 3;
    localparam int unsigned OCW3_RR_BIT    = 1;
    localparam int unsigned OCW3_RIS_BIT   = 0;
    localparam int unsigned ICW4_AEOI_BIT  = 1;

    // Spurious acknowledge returns the lowest-priority line
    localparam logic [2:0] SPURIOUS_LINE = 3'd7;

    // One input request as held in the input register
    typedef struct packed {
        req_kind_t   kind;
        logic        addr_sel;
        logic [7:0]  write_data;
        logic [2:0]  line_index;
        logic        line_level;
    } item_t;

    // Priority encoder result: line index and a found flag
    typedef struct packed {
        logic       found;
        logic [2:0] line;
    } prio_t;

    // Lowest set bit wins (line 0 highest priority)
    function automatic prio_t first_line(input logic [7:0] bits);
        prio_t r;
        r.found = 1'b0;
        r.line  = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (bits[i])
            begin
                r.found = 1'b1;
                r.line  = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/icu8_in_reg.sv
module icu8_in_reg
    import icu8_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Accept a new request when empty or when the held one moves on
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until replaced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/core/icu8_engine.sv
module icu8_engine
    import icu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       int_out
);

    logic [7:0]  request_reg,  request_next;
    logic [7:0]  service_reg,  service_next;
    logic [7:0]  mask_reg,     mask_next;
    logic [4:0]  vec_high_reg, vec_high_next;
    logic [7:0]  levels_reg,   levels_next;
    logic        level_mode_reg, level_mode_next;
    logic        auto_end_reg,   auto_end_next;
    logic        want_icw4_reg,  want_icw4_next;
    logic        want_icw3_reg,  want_icw3_next;
    logic        read_isr_reg,   read_isr_next;
    init_phase_t phase_reg,      phase_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        int_out_reg,   int_out_next;

    prio_t       pend;
    prio_t       serv;
    prio_t       pend_new;
    prio_t       serv_new;
    logic [7:0]  line_bit;
    logic [7:0]  ack_bit;
    logic [7:0]  wd;

    // Move the held request into the result register when it is free
    assign take = item_valid && (!out_valid_reg || out_ready);

    assign wd       = item.write_data;
    assign line_bit = 8'b1 << item.line_index;
    assign pend     = first_line(request_reg & ~mask_reg);
    assign serv     = first_line(service_reg);
    assign ack_bit  = 8'b1 << pend.line;

    // State update and result for one request
    always_comb
    begin
        request_next    = request_reg;
        service_next    = service_reg;
        mask_next       = mask_reg;
        vec_high_next   = vec_high_reg;
        levels_next     = levels_reg;
        level_mode_next = level_mode_reg;
        auto_end_next   = auto_end_reg;
        want_icw4_next  = want_icw4_reg;
        want_icw3_next  = want_icw3_reg;
        read_isr_next   = read_isr_reg;
        phase_next      = phase_reg;
        read_data_next  = 8'd0;

        case (item.kind)
            REQ_WRITE:
            begin
                if (item.addr_sel)
                begin
                    // Data port: init words, else mask
                    case (phase_reg)
                        PHASE_ICW2:
                        begin
                            vec_high_next = wd[7:3];
                            if (want_icw3_reg)
                            begin
                                phase_next = PHASE_ICW3;
                            end
                            else if (want_icw4_reg)
                            begin
                                phase_next = PHASE_ICW4;
                            end
                            else
                            begin
                                phase_next = PHASE_IDLE;
                            end
                        end
                        PHASE_ICW3:
                        begin
                            phase_next = want_icw4_reg ? PHASE_ICW4 : PHASE_IDLE;
                        end
                        PHASE_ICW4:
                        begin
                            auto_end_next = wd[ICW4_AEOI_BIT];
                            phase_next    = PHASE_IDLE;
                        end
                        default:
                        begin
                            mask_next = wd;
                        end
                    endcase
                end
                else if (wd[CMD_ICW1_BIT])
                begin
                    // ICW1: restart the init sequence
                    want_icw4_next  = wd[ICW1_IC4_BIT];
                    want_icw3_next  = !wd[ICW1_SNGL_BIT];
                    level_mode_next = wd[ICW1_LTIM_BIT];
                    mask_next       = 8'd0;
                    service_next    = 8'd0;
                    request_next    = wd[ICW1_LTIM_BIT] ? levels_reg : 8'd0;
                    read_isr_next   = 1'b0;
                    auto_end_next   = 1'b0;
                    phase_next      = PHASE_ICW2;
                end
                else if (wd[CMD_OCW3_BIT])
                begin
                    // OCW3: select readback register
                    if (wd[OCW3_RR_BIT])
                    begin
                        read_isr_next = wd[OCW3_RIS_BIT];
                    end
                end
                else
                begin
                    // OCW2: end of interrupt
                    case (wd[7:5])
                        EOI_NON_SPECIFIC:
                        begin
                            if (serv.found)
                            begin
                                service_next = service_reg & ~(8'b1 << serv.line);
                            end
                        end
                        EOI_SPECIFIC:
                        begin
                            service_next = service_reg & ~(8'b1 << wd[2:0]);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            REQ_READ:
            begin
                if (item.addr_sel)
                begin
                    read_data_next = mask_reg;
                end
                else
                begin
                    read_data_next = read_isr_reg ? service_reg : request_reg;
                end
            end
            REQ_LINE:
            begin
                if (item.line_level)
                begin
                    levels_next = levels_reg | line_bit;
                    if (((levels_reg & line_bit) == 8'd0) || level_mode_reg)
                    begin
                        request_next = request_reg | line_bit;
                    end
                end
                else
                begin
                    levels_next  = levels_reg & ~line_bit;
                    request_next = request_reg & ~line_bit;
                end
            end
            default:
            begin
                // Acknowledge: serve the highest pending unmasked line, else return the spurious vector
                if (!pend.found)
                begin
                    read_data_next = {vec_high_reg, SPURIOUS_LINE};
                end
                else
                begin
                    if (!level_mode_reg)
                    begin
                        request_next = request_reg & ~ack_bit;
                    end
                    if (!auto_end_reg)
                    begin
                        service_next = service_reg | ack_bit;
                    end
                    read_data_next = {vec_high_reg, pend.line};
                end
            end
        endcase
    end

    // Interrupt output from the updated registers
    assign pend_new = first_line(request_next & ~mask_next);
    assign serv_new = first_line(service_next);

    always_comb
    begin
        int_out_next = pend_new.found && (!serv_new.found || (pend_new.line < serv_new.line));
    end

    // Result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg    <= 8'd0;
            service_reg    <= 8'd0;
            mask_reg       <= 8'd0;
            vec_high_reg   <= 5'd0;
            levels_reg     <= 8'd0;
            level_mode_reg <= 1'b0;
            auto_end_reg   <= 1'b0;
            want_icw4_reg  <= 1'b0;
            want_icw3_reg  <= 1'b0;
            read_isr_reg   <= 1'b0;
            phase_reg      <= PHASE_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                request_reg    <= request_next;
                service_reg    <= service_next;
                mask_reg       <= mask_next;
                vec_high_reg   <= vec_high_next;
                levels_reg     <= levels_next;
                level_mode_reg <= level_mode_next;
                auto_end_reg   <= auto_end_next;
                want_icw4_reg  <= want_icw4_next;
                want_icw3_reg  <= want_icw3_next;
                read_isr_reg   <= read_isr_next;
                phase_reg      <= phase_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_data_reg <= read_data_next;
            int_out_reg   <= int_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign int_out   = int_out_reg;

endmodule

FILE: rtl/core/interrupt_controller_8_line_unit.sv
// Eight-line interrupt controller, fixed priority with line 0 highest.
// Input channel (in_valid/in_ready): one request per transfer, selected by
// req_type: register write, register read, request line change or
// interrupt acknowledge. addr_sel picks command or data port.
// Output channel (out_valid/out_ready): exactly one result per request,
// read_data (readback, acknowledge vector, or zero) and int_out, the
// interrupt level after that request.
// A request accepted from the input channel lands in the input register;
// its result is loaded into the output register once that register is
// free, and leaves from there when out_ready is high. Throughput is one
// request per cycle while the receiver does not stall, set by the
// combinational state update between the two registers.
// When the receiver stalls, the result holds in the output register, the
// next request holds in the input register, and in_ready drops only once
// both are full.
// Reset clears all controller state: requests, in-service, mask, vector
// base, line levels, init phase and modes; both registers come up empty.
module interrupt_controller_8_line_unit
    import icu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic       addr_sel,
    input  logic [7:0] write_data,
    input  logic [2:0] line_index,
    input  logic       line_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       int_out
);

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  take;

    // Bundle the request fields
    always_comb
    begin
        in_item.kind       = req_kind_t'(req_type);
        in_item.addr_sel   = addr_sel;
        in_item.write_data = write_data;
        in_item.line_index = line_index;
        in_item.line_level = line_level;
    end

    icu8_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    icu8_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .int_out    (int_out)
    );

endmodule
